FILE: sv/led_matrix_frame_engine_assert.svh
// Assertion macros for the frame engine checker.
`ifndef LED_MATRIX_FRAME_ENGINE_ASSERT_SVH
`define LED_MATRIX_FRAME_ENGINE_ASSERT_SVH

// Clocked assertion that is ignored while reset is asserted.
`define LMFE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LMFE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lmfe_pkg.sv
// Shared types, command codes and helpers for the LED matrix frame engine.
package lmfe_pkg;

    localparam int unsigned ROWS     = 8;
    localparam logic [7:0]  FULL_ROW = 8'hFF;

    localparam logic [3:0] OP_CLEAR       = 4'd0;
    localparam logic [3:0] OP_FILL        = 4'd1;
    localparam logic [3:0] OP_LOAD_ROW    = 4'd2;
    localparam logic [3:0] OP_SET_PIXEL   = 4'd3;
    localparam logic [3:0] OP_SET_COLUMN  = 4'd4;
    localparam logic [3:0] OP_INVERT      = 4'd5;
    localparam logic [3:0] OP_SHIFT_LEFT  = 4'd6;
    localparam logic [3:0] OP_SHIFT_RIGHT = 4'd7;
    localparam logic [3:0] OP_SHIFT_UP    = 4'd8;
    localparam logic [3:0] OP_SHIFT_DOWN  = 4'd9;
    localparam logic [3:0] OP_REFRESH     = 4'd10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       apply;
        logic [2:0] row_sel;
    } dp_ctrl_t;

    // True for the commands that send the whole frame afterwards.
    function automatic logic op_emits(input logic [3:0] op);
        return (op <= OP_REFRESH) && (op != OP_LOAD_ROW);
    endfunction

endpackage

FILE: sv/led_matrix_frame_engine.sv
// Top level of the 8x8 LED matrix frame engine.
//
// Input channel: in_valid/in_stall carry one command per transaction (req_type and its
// operands). Output channel: out_valid/out_stall carry one display row write per
// transaction: digit_address 1 to 8, the row byte, and last_of_frame on the eighth.
// A command is executed on the frame in the cycle it is accepted. Every command except
// load row is then followed by eight row writes, the first shown in the next cycle.
// Load row and the unused codes 11 to 15 produce no writes and leave the block ready.
// A new command is accepted in the same cycle as the eighth row write is taken, so
// with no stall on the output emitting commands run back to back; the row counter
// of the sequencer counts the eight writes of each frame.
// When the receiver stalls, the current row write holds and no command is accepted
// until the eighth write of the frame has been taken.
// Reset clears the frame to all zeros and leaves the block idle and ready.
module led_matrix_frame_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] req_type,
    input  logic [2:0] row_index,
    input  logic [2:0] col_index,
    input  logic       pixel_on,
    input  logic [7:0] data_byte,
    input  logic [3:0] distance,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] digit_address,
    output logic [7:0] row_value,
    output logic       last_of_frame
);
    import lmfe_pkg::*;

    dp_ctrl_t ctrl;

    lmfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    lmfe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .req_type      (req_type),
        .row_index     (row_index),
        .col_index     (col_index),
        .pixel_on      (pixel_on),
        .data_byte     (data_byte),
        .distance      (distance),
        .digit_address (digit_address),
        .row_value     (row_value),
        .last_of_frame (last_of_frame)
    );

endmodule

FILE: sv/lmfe_datapath.sv
// Frame storage, command execution and row readout of the frame engine.
module lmfe_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  lmfe_pkg::dp_ctrl_t ctrl,
    input  logic [3:0]        req_type,
    input  logic [2:0]        row_index,
    input  logic [2:0]        col_index,
    input  logic              pixel_on,
    input  logic [7:0]        data_byte,
    input  logic [3:0]        distance,
    output logic [3:0]        digit_address,
    output logic [7:0]        row_value,
    output logic              last_of_frame
);
    import lmfe_pkg::*;

    logic [7:0] frame_reg  [ROWS];
    logic [7:0] frame_next [ROWS];
    logic [7:0] cmd_rows   [ROWS];
    logic       long_shift;
    logic [2:0] shift_amt;
    logic [3:0] src_idx;

    assign long_shift = distance[3];
    assign shift_amt  = distance[2:0];

    always_comb
    begin
        src_idx = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            cmd_rows[i] = frame_reg[i];
        end
        case (req_type)
            OP_CLEAR:
            begin
                for (int i = 0; i < ROWS; i++) cmd_rows[i] = '0;
            end
            OP_FILL:
            begin
                for (int i = 0; i < ROWS; i++) cmd_rows[i] = FULL_ROW;
            end
            OP_LOAD_ROW:
            begin
                cmd_rows[row_index] = data_byte;
            end
            OP_SET_PIXEL:
            begin
                cmd_rows[row_index][col_index] = pixel_on;
            end
            OP_SET_COLUMN:
            begin
                for (int i = 0; i < ROWS; i++) cmd_rows[i][col_index] = data_byte[i];
            end
            OP_INVERT:
            begin
                for (int i = 0; i < ROWS; i++) cmd_rows[i] = frame_reg[i] ^ FULL_ROW;
            end
            OP_SHIFT_LEFT:
            begin
                for (int i = 0; i < ROWS; i++)
                    cmd_rows[i] = long_shift ? 8'h00 : (frame_reg[i] << shift_amt);
            end
            OP_SHIFT_RIGHT:
            begin
                for (int i = 0; i < ROWS; i++)
                    cmd_rows[i] = long_shift ? 8'h00 : (frame_reg[i] >> shift_amt);
            end
            OP_SHIFT_UP:
            begin
                // Row i takes the row distance places below it, zero past the bottom.
                for (int i = 0; i < ROWS; i++)
                begin
                    src_idx = 4'(i) + {1'b0, shift_amt};
                    cmd_rows[i] = (long_shift || src_idx[3]) ? 8'h00
                                                              : frame_reg[src_idx[2:0]];
                end
            end
            OP_SHIFT_DOWN:
            begin
                for (int i = 0; i < ROWS; i++)
                begin
                    src_idx = 4'(i) - {1'b0, shift_amt};
                    cmd_rows[i] = (long_shift || src_idx[3]) ? 8'h00
                                                              : frame_reg[src_idx[2:0]];
                end
            end
            default:
            begin
                for (int i = 0; i < ROWS; i++) cmd_rows[i] = frame_reg[i];
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            frame_next[i] = ctrl.apply ? cmd_rows[i] : frame_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++) frame_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < ROWS; i++) frame_reg[i] <= frame_next[i];
        end
    end

    assign row_value     = frame_reg[ctrl.row_sel];
    assign digit_address = {1'b0, ctrl.row_sel} + 4'd1;
    assign last_of_frame = (ctrl.row_sel == 3'd7);

endmodule

FILE: sv/lmfe_ctrl.sv
// Command sequencer of the frame engine: accepts commands and walks the row writes.
module lmfe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         req_type,
    output logic               out_valid,
    input  logic               out_stall,
    output lmfe_pkg::dp_ctrl_t ctrl
);
    import lmfe_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       ready;
    logic       in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ready      = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                // The next command may enter as the eighth row write leaves.
                ready = (cnt_reg == 3'd7) && !out_stall;
                if (!out_stall)
                begin
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        in_accept = in_valid && ready;
        if (in_accept)
        begin
            cnt_next   = '0;
            state_next = op_emits(req_type) ? ST_EMIT : ST_IDLE;
        end

        in_stall     = !ready;
        ctrl.apply   = in_accept;
        ctrl.row_sel = cnt_reg;
    end

endmodule

FILE: sv/lmfe_checker.sv
// Port-level checker for the frame engine and its bind to the top level.
`include "led_matrix_frame_engine_assert.svh"

module lmfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [3:0] req_type,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] digit_address,
    input logic [7:0] row_value,
    input logic       last_of_frame
);
    import lmfe_pkg::*;

    `LMFE_ASSERT_RST(a_idle_in_reset, !rst_n |-> !out_valid, "output valid during reset")
    `LMFE_ASSERT(a_hold_on_stall,
        out_valid && out_stall |=> out_valid && $stable(digit_address) && $stable(row_value),
        "stalled row write changed")
    `LMFE_ASSERT(a_last_is_eighth, out_valid && last_of_frame |-> digit_address == 4'd8,
        "last of frame not on digit 8")
    `LMFE_ASSERT(a_rows_in_order,
        out_valid && !out_stall && !last_of_frame |=>
            out_valid && digit_address == $past(digit_address) + 4'd1,
        "row writes not consecutive")
    `LMFE_ASSERT(a_load_silent,
        in_valid && !in_stall && req_type == OP_LOAD_ROW |=> !out_valid,
        "load row produced a row write")

endmodule

bind led_matrix_frame_engine lmfe_checker u_lmfe_checker (.*);
